// File: sv/atpt_pkg.sv
// atpt_pkg: shared constants, codes and control structs for the allocation
// tracking probe table. Used by atpt_ctrl, atpt_dp and alloc_track_probe_table.
`timescale 1ns / 1ps
package atpt_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LEN_W     = IDX_W + 1;
  localparam int DATA_W    = 64;
  localparam int FUNC_W    = 2;
  localparam int ST_W      = 2;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

  localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UPDATE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd3;

  localparam logic [1:0] WR_CLEAR   = 2'd0;
  localparam logic [1:0] WR_INSERT  = 2'd1;
  localparam logic [1:0] WR_RELEASE = 2'd2;
  localparam logic [1:0] WR_UPDATE  = 2'd3;

  localparam logic [2:0] RES_ZERO = 3'd0;
  localparam logic [2:0] RES_FULL = 3'd1;
  localparam logic [2:0] RES_BAD  = 3'd2;
  localparam logic [2:0] RES_INS  = 3'd3;
  localparam logic [2:0] RES_OK   = 3'd4;
  localparam logic [2:0] RES_READ = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       clr_en;
    logic       div_step;
    logic       probe_next;
    logic       rd_probe;
    logic       wr_en;
    logic [1:0] wr_kind;
    logic       res_en;
    logic [2:0] res_op;
    logic       out_load;
  } atpt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ptr_zero;
    logic              slot_bad;
    logic              div_last;
    logic              rd_ptr_zero;
    logic              rd_ptr_match;
    logic              probe_last;
    logic              clr_last;
  } atpt_sts_t;

endpackage

// File: sv/atpt_dp.sv
// atpt_dp: datapath of the probe table: slot memories, item registers,
// bit-serial modulo unit, probe index and result registers. Uses atpt_pkg.
`timescale 1ns / 1ps
module atpt_dp import atpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  atpt_cmd_t         cmd,
  output atpt_sts_t         sts,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_table_len,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_ptr_value,
  input  logic [DATA_W-1:0] in_req_size,
  input  logic [DATA_W-1:0] in_caller_addr,
  input  logic [IDX_W-1:0]  in_slot_index,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_slot_out,
  output logic [DATA_W-1:0] out_ptr_out,
  output logic [DATA_W-1:0] out_size_out,
  output logic [DATA_W-1:0] out_caller_out
);

  logic [DATA_W-1:0] mem_ptr    [DEPTH];
  logic [DATA_W-1:0] mem_size   [DEPTH];
  logic [DATA_W-1:0] mem_caller [DEPTH];

  logic [LEN_W-1:0]     len_cfg_r;
  logic [LEN_W-1:0]     len_use;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [FUNC_W-1:0]    func_r;
  logic [DATA_W-1:0]    ptr_r, size_r, caller_r, div_sh_r;
  logic [IDX_W-1:0]     slot_r;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LEN_W-1:0]     probe_cnt_r;
  logic [LEN_W:0]       div_t;
  logic [LEN_W-1:0]     idx_inc;
  logic [LEN_W-1:0]     probe_cnt_inc;

  logic [DATA_W-1:0] rd_ptr_r, rd_size_r, rd_caller_r;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_ptr, wr_size, wr_caller;

  logic [ST_W-1:0]   res_status_r;
  logic [IDX_W-1:0]  res_slot_r;
  logic [DATA_W-1:0] res_ptr_r, res_size_r, res_caller_r;

  always_comb begin
    if (len_cfg_r == '0) begin
      len_use = LEN_W'(1);
    end else if (len_cfg_r > LEN_W'(DEPTH)) begin
      len_use = LEN_W'(DEPTH);
    end else begin
      len_use = len_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LEN_RESET;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_cfg_r <= cfg_table_len;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  // remainder step and probe wrap
  assign div_t         = {rem_r, div_sh_r[DATA_W-1]};
  assign idx_inc       = rem_r + LEN_W'(1);
  assign probe_cnt_inc = probe_cnt_r + LEN_W'(1);

  always_comb begin
    rem_nxt = rem_r;
    if (cmd.div_step) begin
      if (div_t >= {1'b0, len_use}) begin
        rem_nxt = LEN_W'(div_t - {1'b0, len_use});
      end else begin
        rem_nxt = div_t[LEN_W-1:0];
      end
    end else if (cmd.probe_next) begin
      rem_nxt = (idx_inc == len_use) ? '0 : idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r      <= in_func;
      ptr_r       <= in_ptr_value;
      size_r      <= in_req_size;
      caller_r    <= in_caller_addr;
      slot_r      <= in_slot_index;
      div_sh_r    <= in_ptr_value;
      rem_r       <= '0;
      div_cnt_r   <= '0;
      probe_cnt_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      if (cmd.div_step) begin
        div_sh_r  <= {div_sh_r[DATA_W-2:0], 1'b0};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.probe_next) begin
        probe_cnt_r <= probe_cnt_inc;
      end
    end
  end

  assign rd_addr = cmd.rd_probe ? rem_r[IDX_W-1:0] : slot_r;

  always_comb begin
    wr_addr   = slot_r;
    wr_ptr    = '0;
    wr_size   = '0;
    wr_caller = '0;
    case (cmd.wr_kind)
      WR_CLEAR: begin
        wr_addr = clr_cnt_r;
      end
      WR_INSERT: begin
        wr_addr   = rem_r[IDX_W-1:0];
        wr_ptr    = ptr_r;
        wr_size   = size_r;
        wr_caller = caller_r;
      end
      WR_RELEASE: begin
        wr_addr = slot_r;
      end
      WR_UPDATE: begin
        wr_ptr    = rd_ptr_r;
        wr_size   = size_r;
        wr_caller = caller_r;
      end
      default: begin
        wr_addr = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_ptr[wr_addr]    <= wr_ptr;
      mem_size[wr_addr]   <= wr_size;
      mem_caller[wr_addr] <= wr_caller;
    end
    rd_ptr_r    <= mem_ptr[rd_addr];
    rd_size_r   <= mem_size[rd_addr];
    rd_caller_r <= mem_caller[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_ptr_r    <= '0;
      res_size_r   <= '0;
      res_caller_r <= '0;
      case (cmd.res_op)
        RES_ZERO: begin
          res_status_r <= ST_ZERO;
          res_slot_r   <= '0;
        end
        RES_FULL: begin
          res_status_r <= ST_FULL;
          res_slot_r   <= '0;
        end
        RES_INS: begin
          res_status_r <= ST_OK;
          res_slot_r   <= rem_r[IDX_W-1:0];
        end
        RES_OK: begin
          res_status_r <= ST_OK;
          res_slot_r   <= slot_r;
        end
        RES_READ: begin
          res_status_r <= ST_OK;
          res_slot_r   <= slot_r;
          res_ptr_r    <= rd_ptr_r;
          res_size_r   <= rd_size_r;
          res_caller_r <= rd_caller_r;
        end
        default: begin
          res_status_r <= ST_BAD;
          res_slot_r   <= slot_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status     <= res_status_r;
      out_slot_out   <= res_slot_r;
      out_ptr_out    <= res_ptr_r;
      out_size_out   <= res_size_r;
      out_caller_out <= res_caller_r;
    end
  end

  always_comb begin
    sts.func         = func_r;
    sts.ptr_zero     = (ptr_r == '0);
    sts.slot_bad     = ({1'b0, slot_r} >= len_use);
    sts.div_last     = (div_cnt_r == '1);
    sts.rd_ptr_zero  = (rd_ptr_r == '0);
    sts.rd_ptr_match = (rd_ptr_r == ptr_r);
    sts.probe_last   = (probe_cnt_inc == len_use);
    sts.clr_last     = (clr_cnt_r == '1);
  end

endmodule

// File: sv/atpt_ctrl.sv
// atpt_ctrl: controller state machine of the probe table: clearing pass,
// item sequencing and the output valid. Uses atpt_pkg, drives atpt_dp.
`timescale 1ns / 1ps
module atpt_ctrl import atpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  atpt_sts_t sts,
  output atpt_cmd_t cmd,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DECODE    = 4'd2;
  localparam logic [3:0] S_DIV       = 4'd3;
  localparam logic [3:0] S_PROBE_RD  = 4'd4;
  localparam logic [3:0] S_PROBE_CHK = 4'd5;
  localparam logic [3:0] S_SLOT_RD   = 4'd6;
  localparam logic [3:0] S_SLOT_CHK  = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en  = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func == FN_INSERT) begin
          if (sts.ptr_zero) begin
            cmd.res_en = 1'b1;
            cmd.res_op = RES_ZERO;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end else if (sts.slot_bad) begin
          cmd.res_en = 1'b1;
          cmd.res_op = RES_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SLOT_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        cmd.rd_probe = 1'b1;
        state_nxt    = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts.rd_ptr_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_kind = WR_INSERT;
          cmd.res_en  = 1'b1;
          cmd.res_op  = RES_INS;
          state_nxt   = S_DONE;
        end else if (sts.probe_last) begin
          cmd.res_en = 1'b1;
          cmd.res_op = RES_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_SLOT_RD: begin
        state_nxt = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        cmd.res_en = 1'b1;
        cmd.res_op = RES_BAD;
        state_nxt  = S_DONE;
        case (sts.func)
          FN_RELEASE: begin
            if (sts.rd_ptr_match) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_kind = WR_RELEASE;
              cmd.res_op  = RES_OK;
            end
          end
          FN_UPDATE: begin
            if (!sts.rd_ptr_zero) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_kind = WR_UPDATE;
              cmd.res_op  = RES_OK;
            end
          end
          FN_READ: begin
            cmd.res_op = RES_READ;
          end
          default: begin
            cmd.res_op = RES_BAD;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall && !cmd.accept)
    else $error("item taken during clearing pass");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result overwritten before transfer");

  a_div_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && sts.div_last |=> state_r == S_PROBE_RD)
    else $error("modulo did not hand off to probe");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> state_r == S_CLEAR || state_r == S_PROBE_CHK || state_r == S_SLOT_CHK)
    else $error("table write outside a write state");

endmodule

// File: sv/alloc_track_probe_table.sv
// alloc_track_probe_table: top level of the allocation tracking table.
// Depends on atpt_pkg, atpt_ctrl and atpt_dp.
//
// Input channel in_*: func, ptr_value, req_size, caller_addr, slot_index.
// A transfer happens when in_valid is high and in_stall is low. Each item
// gives exactly one result on the out_* channel (status, slot_out, ptr_out,
// size_out, caller_out), transferred when out_valid is high and out_stall low.
// cfg_table_len sets the slots in use; cfg_ready is always high.
// Items are worked one at a time. Release, update and read go through
// decode, one registered memory read, check and load from transfer to result.
// Insert runs a bit-serial modulo of the pointer by the length in use,
// then probes slot by slot (registered memory read and compare).
// Reset (rst_n low at a clock edge) clears the table with a pass over all
// 1024 slots, one slot per cycle, during which in_stall stays high.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile and holds at its end until the register
// frees.
`timescale 1ns / 1ps
module alloc_track_probe_table import atpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_ptr_value,
  input  logic [DATA_W-1:0] in_req_size,
  input  logic [DATA_W-1:0] in_caller_addr,
  input  logic [IDX_W-1:0]  in_slot_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_slot_out,
  output logic [DATA_W-1:0] out_ptr_out,
  output logic [DATA_W-1:0] out_size_out,
  output logic [DATA_W-1:0] out_caller_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_table_len
);

  atpt_cmd_t cmd;
  atpt_sts_t sts;

  assign cfg_ready = 1'b1;

  atpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  atpt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_table_len  (cfg_table_len),
    .in_func        (in_func),
    .in_ptr_value   (in_ptr_value),
    .in_req_size    (in_req_size),
    .in_caller_addr (in_caller_addr),
    .in_slot_index  (in_slot_index),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_ptr_out    (out_ptr_out),
    .out_size_out   (out_size_out),
    .out_caller_out (out_caller_out)
  );

endmodule
